// File: rtl/tlc_pkg.sv
package tlc_pkg;

  localparam int CNT_W      = 16;
  localparam int BASE_W     = 15;
  localparam int GAIN_SH    = 4;
  localparam int SCALE_W    = BASE_W + GAIN_SH;
  localparam int CH_SHIFT   = 10;
  localparam int CH_W       = CNT_W + SCALE_W - CH_SHIFT;
  localparam int RATIO_SH   = 10;
  localparam int Q_W        = 11;
  localparam int COEF_W     = 10;
  localparam int PROD_W     = CH_W + COEF_W;
  localparam int LUX_SHIFT  = 14;
  localparam int LUX_W      = 17;
  localparam int SEGMENTS   = 7;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [BASE_W-1:0] SCALE_T13  = 15'h7517;
  localparam logic [BASE_W-1:0] SCALE_T101 = 15'h0FE7;
  localparam logic [BASE_W-1:0] SCALE_T402 = 15'h0400;

  localparam logic [1:0] ITIME_13  = 2'd0;
  localparam logic [1:0] ITIME_101 = 2'd1;
  localparam logic [1:0] ITIME_402 = 2'd2;

  localparam logic [1:0] REG_ITIME    = 2'd0;
  localparam logic [1:0] REG_LOW_GAIN = 2'd1;
  localparam logic [1:0] REG_PKG_VAR  = 2'd2;

  localparam logic [LUX_W-1:0] LUX_MAX = '1;

  typedef struct packed {
    logic [1:0] itime;
    logic       low_gain;
    logic       pkg_var;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic            pkg_var;
  } chan_t;

  typedef struct packed {
    logic  valid;
    chan_t chan;
  } chan_word_t;

  typedef struct packed {
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] m;
  } slope_t;

  localparam logic [COEF_W-1:0] BRK_TAB [0:1][0:SEGMENTS-1] = '{
    '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
    '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}
  };
  localparam logic [COEF_W-1:0] B_TAB [0:1][0:SEGMENTS-1] = '{
    '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018},
    '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037}
  };
  localparam logic [COEF_W-1:0] M_TAB [0:1][0:SEGMENTS-1] = '{
    '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012},
    '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b}
  };

  function automatic logic [SCALE_W-1:0] scale_of(cfg_t cfg);
    logic [BASE_W-1:0] base;
    unique case (cfg.itime)
      ITIME_13:  base = SCALE_T13;
      ITIME_101: base = SCALE_T101;
      default:   base = SCALE_T402;
    endcase
    return cfg.low_gain ? {base, {GAIN_SH{1'b0}}} : {{GAIN_SH{1'b0}}, base};
  endfunction

  // First segment whose break point is not below the ratio; past the last, zero slopes
  function automatic slope_t slope_lookup(logic pv, logic [Q_W-1:0] ratio);
    slope_t s;
    logic   hit;
    s   = '0;
    hit = 1'b0;
    for (int k = 0; k < SEGMENTS; k++) begin
      if (!hit && ratio <= Q_W'(BRK_TAB[pv][k])) begin
        s.b = B_TAB[pv][k];
        s.m = M_TAB[pv][k];
        hit = 1'b1;
      end
    end
    return s;
  endfunction

endpackage

// File: rtl/tlc_chan_if.sv
interface tlc_in_if import tlc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] broadband_count;
  logic [CNT_W-1:0] infrared_count;

  modport source (output valid, broadband_count, infrared_count, input ready);
  modport sink (input valid, broadband_count, infrared_count, output ready);
endinterface

interface tlc_out_if import tlc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LUX_W-1:0] lux;
  logic             saturated;

  modport source (output valid, lux, saturated, input ready);
  modport sink (input valid, lux, saturated, output ready);
endinterface

// File: rtl/tlc_regs.sv
module tlc_regs import tlc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.itime    <= ITIME_402;
      cfg.low_gain <= 1'b0;
      cfg.pkg_var  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ITIME:    cfg.itime    <= pwdata[1:0];
        REG_LOW_GAIN: cfg.low_gain <= pwdata[0];
        REG_PKG_VAR:  cfg.pkg_var  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ITIME:    prdata = APB_DW'(cfg.itime);
      REG_LOW_GAIN: prdata = APB_DW'(cfg.low_gain);
      REG_PKG_VAR:  prdata = APB_DW'(cfg.pkg_var);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: rtl/tlc_div.sv
module tlc_div import tlc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  chan_word_t       din,
  output chan_word_t       dout,
  output logic [Q_W-1:0]   quot
);

  localparam int RW   = CH_W + RATIO_SH + 1;
  localparam int NSTG = Q_W;

  chan_word_t       stg  [0:NSTG];
  logic [RW-1:0]    rem  [0:NSTG];
  logic [Q_W-1:0]   q    [0:NSTG];
  logic             zero [0:NSTG];
  logic             over [0:NSTG];

  logic din_zero;
  logic din_over;

  // quotient of (ch1 << 10) / ch0 reaches 2^11 exactly when ch1 >= 2*ch0
  assign din_zero = (din.chan.ch0 == '0);
  assign din_over = !din_zero && ({1'b0, din.chan.ch1} >= {din.chan.ch0, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else if (en) begin
      stg[0].valid <= din.valid;
    end
    if (en) begin
      stg[0].chan <= din.chan;
      zero[0]     <= din_zero;
      over[0]     <= din_over;
      rem[0]      <= (din_zero || din_over) ? '0 :
                     {1'b0, din.chan.ch1, {RATIO_SH{1'b0}}};
      q[0]        <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= NSTG; k++) begin : g_step
    logic [RW-1:0] dvs;
    logic [RW:0]   trial;
    logic          take;

    assign dvs   = RW'(stg[k-1].chan.ch0) << (NSTG - k);
    assign trial = {1'b0, rem[k-1]} - {1'b0, dvs};
    assign take  = !trial[RW];

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k].valid <= 1'b0;
      end else if (en) begin
        stg[k].valid <= stg[k-1].valid;
      end
      if (en) begin
        stg[k].chan <= stg[k-1].chan;
        zero[k]     <= zero[k-1];
        over[k]     <= over[k-1];
        rem[k]      <= take ? trial[RW-1:0] : rem[k-1];
        q[k]        <= {q[k-1][Q_W-2:0], take};
      end
    end
  end

  assign dout = stg[NSTG];

  always_comb begin
    priority if (zero[NSTG]) begin
      quot = '0;
    end else if (over[NSTG]) begin
      quot = '1;
    end else begin
      quot = q[NSTG];
    end
  end

endmodule

// File: rtl/tlc_back.sv
module tlc_back import tlc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  chan_word_t       din,
  input  logic [Q_W-1:0]   quot,
  output logic             valid,
  output logic [LUX_W-1:0] lux,
  output logic             saturated
);

  localparam int RND_W  = PROD_W + 1;
  localparam int FULL_W = RND_W - LUX_SHIFT;

  logic [Q_W:0]   ratio_sum;
  logic [Q_W-1:0] ratio;

  logic              l_valid;
  logic [CH_W-1:0]   l_ch0;
  logic [CH_W-1:0]   l_ch1;
  slope_t            l_slope;

  logic              m_valid;
  logic [PROD_W-1:0] m_pos;
  logic [PROD_W-1:0] m_neg;

  logic              d_valid;
  logic [PROD_W-1:0] d_diff;

  logic [RND_W-1:0]  rnd;
  logic [FULL_W-1:0] full;
  logic              clip;

  // round the quotient to 1/512 units
  assign ratio_sum = {1'b0, quot} + (Q_W+1)'(1);
  assign ratio     = ratio_sum[Q_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
      m_valid <= 1'b0;
      d_valid <= 1'b0;
      valid   <= 1'b0;
    end else if (en) begin
      l_valid <= din.valid;
      m_valid <= l_valid;
      d_valid <= m_valid;
      valid   <= d_valid;
    end
    if (en) begin
      l_ch0   <= din.chan.ch0;
      l_ch1   <= din.chan.ch1;
      l_slope <= slope_lookup(din.chan.pkg_var, ratio);
      m_pos   <= PROD_W'(l_ch0) * PROD_W'(l_slope.b);
      m_neg   <= PROD_W'(l_ch1) * PROD_W'(l_slope.m);
      d_diff  <= (m_pos > m_neg) ? (m_pos - m_neg) : '0;
      lux       <= clip ? LUX_MAX : full[LUX_W-1:0];
      saturated <= clip;
    end
  end

  assign rnd  = {1'b0, d_diff} + (RND_W'(1) << (LUX_SHIFT - 1));
  assign full = rnd[RND_W-1:LUX_SHIFT];
  assign clip = |full[FULL_W-1:LUX_W];

endmodule

// File: rtl/two_channel_lux_calc.sv
// channel   dir  word
// samples   in   broadband_count[15:0], infrared_count[15:0]
// results   out  lux[16:0], saturated
// apb       in   psel/penable/pwrite/paddr[3:0]/pwdata[31:0], prdata/pready out
//
// One word accepted per cycle unless a held result stalls the pipe; the channel
// ratio is formed by the eleven-stage restoring divider.
// Synchronous reset clears all valid bits and loads the register defaults.
// A result held at the output stalls every stage at once; nothing is dropped.
module two_channel_lux_calc import tlc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tlc_in_if.sink            samples,
  tlc_out_if.source         results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PW = CNT_W + SCALE_W;

  cfg_t             cfg;
  logic             en;
  logic [SCALE_W-1:0] scale;
  logic [PW-1:0]    prod0;
  logic [PW-1:0]    prod1;
  chan_word_t       s_word;
  chan_word_t       div_word;
  logic [Q_W-1:0]   quot;

  tlc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // advance the whole pipe unless the output word is waiting
  assign en            = !results.valid || results.ready;
  assign samples.ready = en;

  assign scale = scale_of(cfg);
  assign prod0 = PW'(samples.broadband_count) * PW'(scale);
  assign prod1 = PW'(samples.infrared_count) * PW'(scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_word.valid <= 1'b0;
    end else if (en) begin
      s_word.valid <= samples.valid;
    end
    if (en) begin
      s_word.chan.ch0     <= prod0[CH_SHIFT +: CH_W];
      s_word.chan.ch1     <= prod1[CH_SHIFT +: CH_W];
      s_word.chan.pkg_var <= cfg.pkg_var;
    end
  end

  tlc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (s_word),
    .dout (div_word),
    .quot (quot)
  );

  tlc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .din       (div_word),
    .quot      (quot),
    .valid     (results.valid),
    .lux       (results.lux),
    .saturated (results.saturated)
  );

  a_sat_max : assert property (@(posedge clk) disable iff (rst)
    results.valid && results.saturated |-> results.lux == LUX_MAX)
    else $error("saturated word without clipped lux");

  a_ready_free : assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> samples.ready)
    else $error("input stalled with empty output stage");

  a_reset_clear : assert property (@(posedge clk)
    $past(rst) |-> !results.valid)
    else $error("output word valid straight after reset");

endmodule

// File: bench/two_channel_lux_calc_checker.sv
module two_channel_lux_calc_checker import tlc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tlc_in_if                 samples,
  tlc_out_if                results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int unsigned       fail_count,
  output int unsigned       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LUX_W-1:0] lux;
    logic             saturated;
  } lux_word_t;

  localparam longint unsigned T13_SCALE  = 64'h7517;
  localparam longint unsigned T101_SCALE = 64'h0FE7;
  localparam longint unsigned T402_SCALE = 64'h0400;
  localparam longint unsigned LUX_LIMIT  = 64'd131071;

  localparam int unsigned KNEE [2][SEGMENTS] = '{
    '{'h040, 'h080, 'h0c0, 'h100, 'h138, 'h19a, 'h29a},
    '{'h043, 'h085, 'h0c8, 'h10a, 'h14d, 'h19a, 'h29a}
  };
  localparam int unsigned SLOPE_B [2][SEGMENTS] = '{
    '{'h1f2, 'h214, 'h23f, 'h270, 'h16f, 'h0d2, 'h018},
    '{'h204, 'h228, 'h253, 'h282, 'h177, 'h101, 'h037}
  };
  localparam int unsigned SLOPE_M [2][SEGMENTS] = '{
    '{'h1be, 'h2d1, 'h37b, 'h3fe, 'h1fc, 'h0fb, 'h012},
    '{'h1ad, 'h2c1, 'h363, 'h3df, 'h1dd, 'h127, 'h02b}
  };

  cfg_t        setting;
  lux_word_t   expected_lux[$];
  int unsigned errs;

  function automatic lux_word_t predict_lux(logic [CNT_W-1:0] bb, logic [CNT_W-1:0] ir,
                                            cfg_t cfg);
    longint unsigned gain_scale, ch0, ch1, ratio, b, m, pos, neg, diff, lux;
    lux_word_t       w;
    case (cfg.itime)
      ITIME_13:  gain_scale = T13_SCALE;
      ITIME_101: gain_scale = T101_SCALE;
      default:   gain_scale = T402_SCALE;
    endcase
    if (cfg.low_gain) gain_scale = gain_scale << 4;
    ch0 = (64'(bb) * gain_scale) >> 10;
    ch1 = (64'(ir) * gain_scale) >> 10;
    ratio = 0;
    if (ch0 != 0) ratio = (ch1 << 10) / ch0;
    ratio = (ratio + 1) >> 1;
    // walk down so the lowest matching segment wins; past the last knee both slopes stay zero
    b = 0;
    m = 0;
    for (int k = SEGMENTS - 1; k >= 0; k--) begin
      if (ratio <= KNEE[cfg.pkg_var][k]) begin
        b = SLOPE_B[cfg.pkg_var][k];
        m = SLOPE_M[cfg.pkg_var][k];
      end
    end
    pos  = ch0 * b;
    neg  = ch1 * m;
    diff = (pos > neg) ? pos - neg : 0;
    lux  = (diff + 64'd8192) >> 14;
    if (lux > LUX_LIMIT) begin
      w.lux       = '1;
      w.saturated = 1'b1;
    end else begin
      w.lux       = LUX_W'(lux);
      w.saturated = 1'b0;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    lux_word_t want;
    if (rst) begin
      setting.itime    <= ITIME_402;
      setting.low_gain <= 1'b0;
      setting.pkg_var  <= 1'b0;
      expected_lux.delete();
      errs = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ITIME:    setting.itime    <= pwdata[1:0];
          REG_LOW_GAIN: setting.low_gain <= pwdata[0];
          REG_PKG_VAR:  setting.pkg_var  <= pwdata[0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready)
        expected_lux.push_back(predict_lux(samples.broadband_count, samples.infrared_count,
                                           setting));
      if (results.valid && results.ready) begin
        if (expected_lux.size() == 0) begin
          $error("unexpected result word: lux=%0d saturated=%0d",
                 results.lux, results.saturated);
          errs++;
        end else begin
          want = expected_lux.pop_front();
          if (results.lux !== want.lux) begin
            $error("lux: expected %0d, actual %0d", want.lux, results.lux);
            errs++;
          end
          if (results.saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, results.saturated);
            errs++;
          end
        end
      end
    end
    pending    <= expected_lux.size();
    fail_count <= errs;
  end

endmodule

// File: bench/two_channel_lux_calc_tb.sv
module two_channel_lux_calc_tb import tlc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_PER_PHASE = 77;
  localparam int          CYCLE_LIMIT      = 300000;
  localparam int          DRAIN_CYCLES     = 40;
  localparam logic [1:0]  REG_SPARE        = 2'd3;
  localparam int unsigned RATIO_KNEE [7]   = '{64, 128, 192, 256, 312, 410, 666};

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       cycle_count;
  bit                calm;

  tlc_in_if  samples_ch ();
  tlc_out_if results_ch ();

  two_channel_lux_calc u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  two_channel_lux_calc_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples_ch),
    .results    (results_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // hold valid across back-to-back words; drop it only when a gap is drawn
  task automatic send_sample(input logic [CNT_W-1:0] bb, input logic [CNT_W-1:0] ir);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_ch.valid           <= 1'b1;
    samples_ch.broadband_count <= bb;
    samples_ch.infrared_count  <= ir;
    do @(posedge clk); while (!samples_ch.ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic drain_results();
    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly counts whose ratio sweeps the whole segment table, at all magnitudes
  function automatic void pick_sample(output logic [CNT_W-1:0] bb, output logic [CNT_W-1:0] ir);
    int unsigned span, knee, prod;
    span = $urandom_range(1, 16);
    bb   = CNT_W'($urandom) & CNT_W'((32'd1 << span) - 1);
    case ($urandom_range(0, 9))
      0: ir = CNT_W'($urandom);
      1: begin
        bb = CNT_W'($urandom);
        ir = CNT_W'($urandom);
      end
      2: begin
        bb = '1;
        ir = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        knee = $urandom_range(0, 720);
        prod = (bb * knee + $urandom_range(0, 511)) / 512;
        ir   = (prod > 65535) ? '1 : CNT_W'(prod);
      end
    endcase
  endfunction

  initial begin : result_sink
    int stall;
    results_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        results_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_ch.ready <= 1'b1;
      do @(posedge clk); while (!results_ch.valid);
    end
  end

  initial begin
    logic [CNT_W-1:0]  bb, ir;
    logic [APB_DW-1:0] data;
    samples_ch.valid           <= 1'b0;
    samples_ch.broadband_count <= '0;
    samples_ch.infrared_count  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    calm    = 1'b0;
    rst     <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // extremes, then either side of every knee at the reset setting
    send_sample('0, '0);
    send_sample('1, '0);
    send_sample('0, '1);
    send_sample('1, '1);
    foreach (RATIO_KNEE[k]) begin
      send_sample(CNT_W'(4096), CNT_W'(8 * RATIO_KNEE[k]));
      send_sample(CNT_W'(4096), CNT_W'(8 * RATIO_KNEE[k] + 4));
    end
    drain_results();

    for (int p = 0; p < 16; p++) begin
      data      = $urandom;
      data[1:0] = p[1:0];
      write_reg(REG_ITIME, data);
      data    = $urandom;
      data[0] = p[2];
      write_reg(REG_LOW_GAIN, data);
      data    = $urandom;
      data[0] = p[3];
      write_reg(REG_PKG_VAR, data);
      write_reg(REG_SPARE, $urandom);
      psel    <= 1'b0;
      penable <= 1'b0;
      calm = ($urandom_range(0, 3) == 0);
      repeat (RANDOM_PER_PHASE) begin
        if ($urandom_range(0, 24) == 0) calm = !calm;
        pick_sample(bb, ir);
        send_sample(bb, ir);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
